>>> rtl/svpc_pkg.sv
// Shared types, constants and sector coefficient tables for the SVPWM compare calculator.
package svpc_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int VW  = 16;          // internal voltage width
	localparam int PW  = 34;          // projection magnitude width
	localparam int QB  = 35;          // quotient bits per division
	localparam int DVR = 24;          // divisor / partial remainder width
	localparam int DVD = QB + DVR;    // dividend width
	localparam int TW  = 42;          // signed time arithmetic width

	localparam logic [16:0] SQRT3_Q16  = 17'd113512;
	localparam logic [15:0] PERIOD_RST = 16'd1000;
	localparam logic [14:0] BUS_RST    = 15'd24000;
	localparam logic [14:0] LIMIT_RST  = 15'd13856;

	typedef enum logic [1:0] {
		REG_PERIOD = 2'd0,
		REG_BUS    = 2'd1,
		REG_LIMIT  = 2'd2
	} reg_idx_t;

	// One classified vector handed from the front to the back.
	typedef struct packed {
		logic [2:0]    k;
		logic          neg1;
		logic          neg2;
		logic [PW-1:0] mag1;
		logic [PW-1:0] mag2;
		logic          clamp;
		logic [31:0]   msq;
	} job_t;

	function automatic logic signed [2:0] cos2_start(input logic [2:0] k);
		case (k)
			3'd0: return 3'sd2;
			3'd1: return 3'sd1;
			3'd2: return -3'sd1;
			3'd3: return -3'sd2;
			3'd4: return -3'sd1;
			default: return 3'sd1;
		endcase
	endfunction

	function automatic logic signed [2:0] sin2_start(input logic [2:0] k);
		case (k)
			3'd0: return 3'sd0;
			3'd1: return 3'sd1;
			3'd2: return 3'sd1;
			3'd3: return 3'sd0;
			3'd4: return -3'sd1;
			default: return -3'sd1;
		endcase
	endfunction

	function automatic logic signed [2:0] sin2_end(input logic [2:0] k);
		case (k)
			3'd0: return 3'sd1;
			3'd1: return 3'sd1;
			3'd2: return 3'sd0;
			3'd3: return -3'sd1;
			3'd4: return -3'sd1;
			default: return 3'sd0;
		endcase
	endfunction

	function automatic logic signed [2:0] cos2_end(input logic [2:0] k);
		case (k)
			3'd0: return 3'sd1;
			3'd1: return -3'sd1;
			3'd2: return -3'sd2;
			3'd3: return -3'sd1;
			3'd4: return 3'sd1;
			default: return 3'sd2;
		endcase
	endfunction

endpackage

>>> rtl/svpc_front.sv
// Front end: saturate the input vector, pick the sector, form both projections.
module svpc_front #(
	parameter int DATA_WIDTH = svpc_pkg::DATA_WIDTH_DEF
) (
	input  logic                  in_valid,
	input  logic [DATA_WIDTH-1:0] u_alpha,
	input  logic [DATA_WIDTH-1:0] u_beta,
	input  logic [14:0]           lim,
	input  logic                  q_full,
	output logic                  in_ready,
	output logic                  push,
	output svpc_pkg::job_t        job
);
	import svpc_pkg::*;

	localparam int EW = (DATA_WIDTH > VW) ? DATA_WIDTH : VW;
	localparam logic signed [EW-1:0] VMAX = EW'(32767);
	localparam logic signed [EW-1:0] VMIN = EW'(-32768);

	function automatic logic signed [VW-1:0] sat_v(input logic [DATA_WIDTH-1:0] raw);
		logic signed [EW-1:0] x;
		x = EW'($signed(raw));
		if (x > VMAX) x = VMAX;
		if (x < VMIN) x = VMIN;
		return x[VW-1:0];
	endfunction

	logic signed [VW-1:0] a, b;
	logic signed [32:0]   aa, bb;
	logic signed [34:0]   a3;
	logic                 upper;
	logic [2:0]           k;
	logic signed [36:0]   a_s, b_s, p1, p2;
	logic [31:0]          msq;
	logic [29:0]          lim_sq;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		a      = sat_v(u_alpha);
		b      = sat_v(u_beta);
		aa     = 33'(a * a);
		bb     = 33'(b * b);
		a3     = 35'(aa) * 35'sd3;
		upper  = (b > 0) || (b == 0 && a >= 0);
		if (a == 0 && b == 0) begin
			k = 3'd0;
		end else if (upper) begin
			if (a > 0 && 35'(bb) < a3) k = 3'd0;
			else if (a < 0 && 35'(bb) <= a3) k = 3'd2;
			else k = 3'd1;
		end else begin
			if (a < 0 && 35'(bb) < a3) k = 3'd3;
			else if (a > 0 && 35'(bb) < a3) k = 3'd5;
			else k = 3'd4;
		end
		a_s    = 37'(a) * 37'($signed({1'b0, SQRT3_Q16}));
		b_s    = 37'(b) <<< 16;
		p1     = a_s * 37'(sin2_end(k)) - b_s * 37'(cos2_end(k));
		p2     = b_s * 37'(cos2_start(k)) - a_s * 37'(sin2_start(k));
		msq    = aa[31:0] + bb[31:0];
		lim_sq = lim * lim;

		job.k     = k;
		job.neg1  = p1[36];
		job.neg2  = p2[36];
		job.mag1  = p1[36] ? PW'(-p1) : PW'(p1);
		job.mag2  = p2[36] ? PW'(-p2) : PW'(p2);
		job.clamp = msq > 32'(lim_sq);
		job.msq   = msq;
	end

endmodule

>>> rtl/svpc_queue.sv
// Two-entry job queue between front and back.
module svpc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  svpc_pkg::job_t din,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output svpc_pkg::job_t dout
);
	import svpc_pkg::*;

	job_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign dout      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

>>> rtl/svpc_back.sv
// Back end: magnitude clamp, active times and compare values, one job at a time.
module svpc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  svpc_pkg::job_t job,
	input  logic [15:0]    period,
	input  logic [14:0]    udc,
	input  logic [14:0]    lim,
	input  logic           out_ready,
	output logic           q_pop,
	output logic           out_valid,
	output logic [14:0]    compare_a,
	output logic [14:0]    compare_b,
	output logic [14:0]    compare_c,
	output logic [2:0]     sector
);
	import svpc_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_SQRT = 8'b0000_0010,
		S_SCL  = 8'b0000_0100,
		S_DIV1 = 8'b0000_1000,
		S_MUL3 = 8'b0001_0000,
		S_MULT = 8'b0010_0000,
		S_DIV2 = 8'b0100_0000,
		S_FIN  = 8'b1000_0000
	} state_t;

	state_t                state_q;
	logic [5:0]            cnt_q;
	logic [2:0]            k_q;
	logic                  neg_q [2];
	logic [PW-1:0]         mag_q [2];
	logic [47:0]           sv_q;
	logic [24:0]           srem_q;
	logic [DVR-1:0]        root_q;
	logic [DVR-1:0]        drem_q [2];
	logic [QB-1:0]         dlo_q [2];
	logic [DVR-1:0]        dvs_q;
	logic signed [TW-1:0]  t_q [2];
	logic                  ov_q;
	logic [14:0]           ca_q, cb_q, cc_q;
	logic [2:0]            sec_q;

	// square root digit step
	logic [26:0]           s_r, s_trial;
	logic                  s_ge;
	// divider lanes
	logic [DVR:0]          d_r [2];
	logic                  d_ge [2];
	logic [DVR-1:0]        d_rem [2];
	logic [QB-1:0]         d_lo [2];
	// multiplies
	logic [PW+14:0]        p_lim [2];
	logic [DVD-1:0]        p_scl [2];
	logic [PW+16:0]        p_s3 [2];
	logic [PW+15:0]        p_per [2];
	// compare stage
	logic signed [TW-1:0]  per_s, both, t0, on_a, on_b, on_c;
	logic [14:0]           half;
	logic                  fin_go;
	logic                  last;

	function automatic logic [14:0] to_cmp(input logic signed [TW-1:0] on,
		input logic signed [TW-1:0] zero, input logic signed [TW-1:0] per,
		input logic [14:0] hp);
		logic signed [TW-1:0] num, c;
		num = (per <<< 3) - ((on <<< 1) + zero);
		c   = num >>> 4;
		if (c < 0) return 15'd0;
		if (c > TW'(hp)) return hp;
		return c[14:0];
	endfunction

	assign s_r     = {srem_q, sv_q[47:46]};
	assign s_trial = {1'b0, root_q, 2'b01};
	assign s_ge    = s_r >= s_trial;
	assign last    = cnt_q == 6'(QB - 1);

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			d_r[i]   = {drem_q[i], dlo_q[i][QB-1]};
			d_ge[i]  = d_r[i] >= {1'b0, dvs_q};
			d_rem[i] = d_ge[i] ? DVR'(d_r[i] - {1'b0, dvs_q}) : d_r[i][DVR-1:0];
			d_lo[i]  = {dlo_q[i][QB-2:0], d_ge[i]};
			p_lim[i] = mag_q[i] * lim;
			p_scl[i] = DVD'({p_lim[i], 8'b0});
			p_s3[i]  = mag_q[i] * SQRT3_Q16;
			p_per[i] = mag_q[i] * period;
		end
	end

	always_comb begin
		per_s = TW'($signed({1'b0, period}));
		half  = period[15:1];
		both  = t_q[0] + t_q[1];
		t0    = (per_s <<< 2) - both;
		case (k_q)
			3'd0: begin on_a = both;    on_b = t_q[1]; on_c = '0;     end
			3'd1: begin on_a = t_q[0];  on_b = both;   on_c = '0;     end
			3'd2: begin on_a = '0;      on_b = both;   on_c = t_q[1]; end
			3'd3: begin on_a = '0;      on_b = t_q[0]; on_c = both;   end
			3'd4: begin on_a = t_q[1];  on_b = '0;     on_c = both;   end
			default: begin on_a = both; on_b = '0;     on_c = t_q[0]; end
		endcase
	end

	assign q_pop  = (state_q == S_IDLE) && q_valid;
	assign fin_go = (state_q == S_FIN) && (!ov_q || out_ready);

	assign out_valid = ov_q;
	assign compare_a = ca_q;
	assign compare_b = cb_q;
	assign compare_c = cc_q;
	assign sector    = sec_q;

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				k_q    <= job.k;
				neg_q  <= '{job.neg1, job.neg2};
				mag_q  <= '{job.mag1, job.mag2};
				sv_q   <= {job.msq, 16'b0};
				srem_q <= '0;
				root_q <= '0;
			end
			S_SQRT: begin
				sv_q   <= {sv_q[45:0], 2'b00};
				srem_q <= s_ge ? 25'(s_r - s_trial) : s_r[24:0];
				root_q <= {root_q[DVR-2:0], s_ge};
			end
			S_SCL: begin
				for (int i = 0; i < 2; i++) begin
					drem_q[i] <= p_scl[i][DVD-1:QB];
					dlo_q[i]  <= p_scl[i][QB-1:0];
				end
				dvs_q <= root_q;
			end
			S_DIV1: begin
				for (int i = 0; i < 2; i++) begin
					drem_q[i] <= d_rem[i];
					dlo_q[i]  <= d_lo[i];
					if (last) mag_q[i] <= d_lo[i][PW-1:0];
				end
			end
			S_MUL3: begin
				for (int i = 0; i < 2; i++) mag_q[i] <= p_s3[i][PW+15:16];
			end
			S_MULT: begin
				for (int i = 0; i < 2; i++) begin
					drem_q[i] <= '0;
					dlo_q[i]  <= p_per[i][PW+15:15];
				end
				dvs_q <= DVR'(udc);
			end
			S_DIV2: begin
				for (int i = 0; i < 2; i++) begin
					drem_q[i] <= d_rem[i];
					dlo_q[i]  <= d_lo[i];
					if (last) t_q[i] <= neg_q[i] ? -TW'(d_lo[i]) : TW'(d_lo[i]);
				end
			end
			default: ;
		endcase
		if (fin_go) begin
			ca_q  <= to_cmp(on_a, t0, per_s, half);
			cb_q  <= to_cmp(on_b, t0, per_s, half);
			cc_q  <= to_cmp(on_c, t0, per_s, half);
			sec_q <= k_q + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (fin_go) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (q_valid) state_q <= job.clamp ? S_SQRT : S_MUL3;
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(DVR - 1)) begin
						cnt_q   <= '0;
						state_q <= S_SCL;
					end
				end
				S_SCL: state_q <= S_DIV1;
				S_DIV1: begin
					cnt_q <= cnt_q + 6'd1;
					if (last) begin
						cnt_q   <= '0;
						state_q <= S_MUL3;
					end
				end
				S_MUL3: state_q <= S_MULT;
				S_MULT: state_q <= S_DIV2;
				S_DIV2: begin
					cnt_q <= cnt_q + 6'd1;
					if (last) begin
						cnt_q   <= '0;
						state_q <= S_FIN;
					end
				end
				S_FIN: if (fin_go) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/svpwm_compare_calculator.sv
// Results come from the back end, which works on one vector at a time; its speed is set by the
// shared bit-serial divider lanes (35 quotient bits per division) and, when the clamp applies,
// by the 24-step square root in the back end.
// The front accepts into a two-entry queue, so up to two vectors wait while one is in work.
// Reset (arst_n low, asynchronous) empties the queue, idles the back end, drops out_valid
// and loads pwm_period 1000, bus_voltage 24000, magnitude_limit 13856.
module svpwm_compare_calculator #(
	parameter int DATA_WIDTH = svpc_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// vector input channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DATA_WIDTH-1:0] u_alpha,
	input  logic [DATA_WIDTH-1:0] u_beta,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [14:0]           compare_a,
	output logic [14:0]           compare_b,
	output logic [14:0]           compare_c,
	output logic [2:0]            sector,
	// register write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [15:0]           cfg_data
);
	import svpc_pkg::*;

	logic [15:0] period_q;
	logic [14:0] bus_q;
	logic [14:0] lim_q;
	logic [14:0] udc;

	logic q_full, q_push, q_pop, q_not_empty;
	job_t f_job, b_job;

	// Register writes are always taken; a transaction to an unknown index is dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			bus_q    <= BUS_RST;
			lim_q    <= LIMIT_RST;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_PERIOD: period_q <= cfg_data;
				REG_BUS:    bus_q    <= cfg_data[14:0];
				REG_LIMIT:  lim_q    <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Treat a zero bus voltage as one so the time division stays defined.
	assign udc = (bus_q == '0) ? 15'd1 : bus_q;

	// Classify the vector and compute its projections in the cycle it is accepted.
	svpc_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.in_valid (in_valid),
		.u_alpha  (u_alpha),
		.u_beta   (u_beta),
		.lim      (lim_q),
		.q_full   (q_full),
		.in_ready (in_ready),
		.push     (q_push),
		.job      (f_job)
	);

	// Hold classified jobs so the front keeps accepting while the back is busy.
	svpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.din       (f_job),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.dout      (b_job)
	);

	// Clamp, time and compare computation; owns the output register.
	svpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_not_empty),
		.job       (b_job),
		.period    (period_q),
		.udc       (udc),
		.lim       (lim_q),
		.out_ready (out_ready),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.compare_a (compare_a),
		.compare_b (compare_b),
		.compare_c (compare_c),
		.sector    (sector)
	);

endmodule

>>> rtl/svpc_checker.sv
// Port-level checker for the SVPWM compare calculator, bound to the top level.
module svpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [14:0] compare_a,
	input logic [14:0] compare_b,
	input logic [14:0] compare_c,
	input logic [2:0]  sector,
	input logic        cfg_ready
);

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(compare_a) && $stable(compare_b)
			&& $stable(compare_c) && $stable(sector))
		else $error("result changed while stalled");

	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sector != 3'd0 && sector != 3'd7)
		else $error("sector out of range");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("register write stalled");

endmodule

bind svpwm_compare_calculator svpc_checker u_svpc_checker (.*);
